@@ hw/rtl/smm_pkg.sv @@
// Package for the square matrix multiplier: opcodes, sizes and the
// IEEE single rounding helper shared by the multiply and add steps.
// No dependencies.
package smm_pkg;

    localparam int SMM_MATRIX_SIZE = 32;

    localparam logic [1:0] OP_WRITE_A = 2'd0;
    localparam logic [1:0] OP_WRITE_B = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [31:0] FP_DEFAULT_NAN = 32'hFFC0_0000;
    localparam logic [31:0] FP_QUIET_BIT   = 32'h0040_0000;

    // Rounds sign, exponent x and mantissa m to nearest-even IEEE single.
    // The value is m / 2^63 * 2^(x - 127); m must be nonzero.
    function automatic logic [31:0] fp_round(input logic s, input logic signed [11:0] x,
                                             input logic [63:0] m);
        logic [63:0]        mm;
        logic signed [11:0] xx;
        logic [11:0]        sh;
        logic               st;
        logic               up;
        logic [24:0]        mant;
        logic [31:0]        res;
        mm = m;
        xx = x;
        st = 1'b0;
        for (int i = 5; i >= 0; i--) begin
            if ((mm >> (64 - (1 << i))) == 64'd0) begin
                mm = mm << (1 << i);
                xx = xx - 12'(1 << i);
            end
        end
        if (xx < 12'sd1) begin
            sh = 12'(12'sd1 - xx);
            if (sh >= 12'd64) begin
                st = |mm;
                mm = 64'd0;
            end else begin
                st = |(mm & ((64'd1 << sh[5:0]) - 64'd1));
                mm = mm >> sh[5:0];
            end
        end
        mant = {1'b0, mm[63:40]};
        st   = st | (|mm[38:0]);
        up   = mm[39] & (st | mm[40]);
        mant = mant + {24'd0, up};
        if (xx < 12'sd1) begin
            res = {s, 7'd0, mant[23], mant[22:0]};
        end else begin
            if (mant[24]) begin
                mant = mant >> 1;
                xx   = xx + 12'sd1;
            end
            if (xx >= 12'sd255) begin
                res = {s, 8'hFF, 23'd0};
            end else begin
                res = {s, xx[7:0], mant[22:0]};
            end
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/smm_if.sv @@
// Valid/ready channel interfaces of the square matrix multiplier.
// Depends on nothing; the top level uses both.
interface smm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [4:0]  row_index;
    logic [4:0]  col_index;
    logic [31:0] element_value;
    modport source (output valid, opcode, row_index, col_index, element_value, input ready);
    modport sink   (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

interface smm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] product_value;
    logic [4:0]  product_row;
    logic [4:0]  product_col;
    modport source (output valid, product_value, product_row, product_col, input ready);
    modport sink   (input valid, product_value, product_row, product_col, output ready);
endinterface

@@ hw/rtl/square_matrix_multiply.sv @@
// Top level of the square matrix multiplier: element stores, sequencer and
// the shared single-precision multiply-add unit. Uses smm_pkg and smm_if.
//
// The block holds two MATRIX_SIZE x MATRIX_SIZE stores of IEEE single words,
// A and B. A write transfer (opcode 0 or 1) stores one element and gives no
// result. A compute transfer (opcode 2) forms C[row][col] by starting from
// +0.0 and adding A[row][k] * B[k][col] for k ascending, with the product
// and the sum each rounded to nearest-even on its own. One shared unit does
// every step in turn for each k: a store read, a mantissa multiply, product
// rounding, operand alignment, the add and sum rounding. The result is then
// loaded into the output register, and the input is ready again in the same
// cycle as the result appears there. The input is taken only while the
// sequencer is idle. A finished result waits in the output register while
// write transfers and a new compute go on; the sequencer stalls at its
// end only if the previous result has not yet been taken. Indices at or
// beyond MATRIX_SIZE turn writes into no-ops and give a compute result of
// +0.0. Store entries hold nothing defined until written.
module square_matrix_multiply
    import smm_pkg::*;
#(
    parameter int MATRIX_SIZE = SMM_MATRIX_SIZE
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smm_in_if.sink    i_in,
    smm_out_if.source o_out
);

    localparam int CELLS = MATRIX_SIZE * MATRIX_SIZE;
    localparam int AW    = $clog2(CELLS);
    localparam int KW    = $clog2(MATRIX_SIZE);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_MRND = 3'd3;
    localparam logic [2:0] S_ALN  = 3'd4;
    localparam logic [2:0] S_ADD  = 3'd5;
    localparam logic [2:0] S_ARND = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [31:0] r_mem_a [CELLS];
    logic [31:0] r_mem_b [CELLS];

    logic [2:0]    r_state;
    logic [KW-1:0] r_k;
    logic [AW-1:0] r_addr_a;
    logic [AW-1:0] r_addr_b;
    logic [4:0]    r_row;
    logic [4:0]    r_col;
    logic [31:0]   r_rd_a;
    logic [31:0]   r_rd_b;
    logic [31:0]   r_acc;
    logic [31:0]   r_prod;

    // Multiply step registers.
    logic [47:0]        r_mp;
    logic signed [11:0] r_mx;
    logic               r_ms;
    logic               r_mspec;
    logic [31:0]        r_mspec_val;

    // Add step registers.
    logic [63:0]        r_big;
    logic [63:0]        r_small;
    logic signed [11:0] r_ax;
    logic               r_as;
    logic               r_sub;
    logic               r_aspec;
    logic [31:0]        r_aspec_val;
    logic [63:0]        r_sum;

    logic        r_out_valid;
    logic [31:0] r_out_value;
    logic [4:0]  r_out_row;
    logic [4:0]  r_out_col;

    logic accept;
    logic in_range;
    logic out_free;
    logic [AW-1:0] wr_addr;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign in_range   = ({2'b0, i_in.row_index} < 7'(MATRIX_SIZE))
                     && ({2'b0, i_in.col_index} < 7'(MATRIX_SIZE));
    assign wr_addr    = AW'(AW'(i_in.row_index) * AW'(MATRIX_SIZE) + AW'(i_in.col_index));
    assign out_free   = !r_out_valid || o_out.ready;

    assign o_out.valid         = r_out_valid;
    assign o_out.product_value = r_out_value;
    assign o_out.product_row   = r_out_row;
    assign o_out.product_col   = r_out_col;

    // Element stores: one write port from the input, one read port each.
    always_ff @(posedge i_clk) begin
        if (accept && in_range && i_in.opcode == OP_WRITE_A) begin
            r_mem_a[wr_addr] <= i_in.element_value;
        end
        if (accept && in_range && i_in.opcode == OP_WRITE_B) begin
            r_mem_b[wr_addr] <= i_in.element_value;
        end
        if (r_state == S_READ) begin
            r_rd_a <= r_mem_a[r_addr_a];
            r_rd_b <= r_mem_b[r_addr_b];
        end
    end

    // Multiply operand decode.
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, m_sign;
    logic [7:0]  ea, eb;
    logic [23:0] ma, mb;

    always_comb begin
        a_nan  = (r_rd_a[30:23] == 8'hFF) && (r_rd_a[22:0] != 23'd0);
        b_nan  = (r_rd_b[30:23] == 8'hFF) && (r_rd_b[22:0] != 23'd0);
        a_inf  = (r_rd_a[30:23] == 8'hFF) && (r_rd_a[22:0] == 23'd0);
        b_inf  = (r_rd_b[30:23] == 8'hFF) && (r_rd_b[22:0] == 23'd0);
        a_zero = (r_rd_a[30:0] == 31'd0);
        b_zero = (r_rd_b[30:0] == 31'd0);
        m_sign = r_rd_a[31] ^ r_rd_b[31];
        ea     = (r_rd_a[30:23] == 8'd0) ? 8'd1 : r_rd_a[30:23];
        eb     = (r_rd_b[30:23] == 8'd0) ? 8'd1 : r_rd_b[30:23];
        ma     = {(r_rd_a[30:23] != 8'd0), r_rd_a[22:0]};
        mb     = {(r_rd_b[30:23] != 8'd0), r_rd_b[22:0]};
    end

    // Add operand decode; the accumulator is the first operand.
    logic        c_nan, p_nan, c_inf, p_inf, c_zero, p_zero, swap;
    logic [31:0] big_op, small_op;
    logic [7:0]  e_big, e_small, d;
    logic [63:0] small_ext;

    always_comb begin
        c_nan    = (r_acc[30:23] == 8'hFF) && (r_acc[22:0] != 23'd0);
        p_nan    = (r_prod[30:23] == 8'hFF) && (r_prod[22:0] != 23'd0);
        c_inf    = (r_acc[30:23] == 8'hFF) && (r_acc[22:0] == 23'd0);
        p_inf    = (r_prod[30:23] == 8'hFF) && (r_prod[22:0] == 23'd0);
        c_zero   = (r_acc[30:0] == 31'd0);
        p_zero   = (r_prod[30:0] == 31'd0);
        swap     = r_prod[30:0] > r_acc[30:0];
        big_op   = swap ? r_prod : r_acc;
        small_op = swap ? r_acc : r_prod;
        e_big    = (big_op[30:23] == 8'd0) ? 8'd1 : big_op[30:23];
        e_small  = (small_op[30:23] == 8'd0) ? 8'd1 : small_op[30:23];
        d        = e_big - e_small;
        small_ext = {1'b0, (small_op[30:23] != 8'd0), small_op[22:0], 39'd0};
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_MUL: begin
                r_mp    <= 48'(ma) * 48'(mb);
                r_mx    <= 12'(ea) + 12'(eb) - 12'sd126;
                r_ms    <= m_sign;
                r_mspec <= a_nan || b_nan || a_inf || b_inf || a_zero || b_zero;
                if (a_nan) begin
                    r_mspec_val <= r_rd_a | FP_QUIET_BIT;
                end else if (b_nan) begin
                    r_mspec_val <= r_rd_b | FP_QUIET_BIT;
                end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
                    r_mspec_val <= FP_DEFAULT_NAN;
                end else if (a_inf || b_inf) begin
                    r_mspec_val <= {m_sign, 8'hFF, 23'd0};
                end else begin
                    r_mspec_val <= {m_sign, 31'd0};
                end
            end
            S_MRND: begin
                r_prod <= r_mspec ? r_mspec_val : fp_round(r_ms, r_mx, {r_mp, 16'd0});
            end
            S_ALN: begin
                r_big <= {1'b0, (big_op[30:23] != 8'd0), big_op[22:0], 39'd0};
                if (d >= 8'd64) begin
                    r_small <= {63'd0, (small_op[30:0] != 31'd0)};
                end else begin
                    r_small <= (small_ext >> d[5:0])
                             | {63'd0, |(small_ext & ((64'd1 << d[5:0]) - 64'd1))};
                end
                r_ax    <= 12'(e_big) + 12'sd1;
                r_as    <= big_op[31];
                r_sub   <= r_acc[31] ^ r_prod[31];
                r_aspec <= c_nan || p_nan || c_inf || p_inf || (c_zero && p_zero);
                if (c_nan) begin
                    r_aspec_val <= r_acc | FP_QUIET_BIT;
                end else if (p_nan) begin
                    r_aspec_val <= r_prod | FP_QUIET_BIT;
                end else if (c_inf && p_inf && (r_acc[31] != r_prod[31])) begin
                    r_aspec_val <= FP_DEFAULT_NAN;
                end else if (c_inf) begin
                    r_aspec_val <= r_acc;
                end else if (p_inf) begin
                    r_aspec_val <= r_prod;
                end else begin
                    r_aspec_val <= {r_acc[31] & r_prod[31], 31'd0};
                end
            end
            S_ADD: begin
                r_sum <= r_sub ? (r_big - r_small) : (r_big + r_small);
            end
            default: begin
            end
        endcase
    end

    // Sequencer and accumulator.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // In the finishing state the output register is either reloaded
            // or still waiting, so it is only emptied in the other states.
            if (o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && i_in.opcode == OP_COMPUTE) begin
                        r_row    <= i_in.row_index;
                        r_col    <= i_in.col_index;
                        r_acc    <= 32'd0;
                        r_k      <= '0;
                        r_addr_a <= AW'(AW'(i_in.row_index) * AW'(MATRIX_SIZE));
                        r_addr_b <= AW'(i_in.col_index);
                        r_state  <= in_range ? S_READ : S_DONE;
                    end
                end
                S_READ: begin
                    r_addr_a <= r_addr_a + AW'(1);
                    r_addr_b <= AW'(r_addr_b + AW'(MATRIX_SIZE));
                    r_state  <= S_MUL;
                end
                S_MUL:  r_state <= S_MRND;
                S_MRND: r_state <= S_ALN;
                S_ALN:  r_state <= S_ADD;
                S_ADD:  r_state <= S_ARND;
                S_ARND: begin
                    if (r_aspec) begin
                        r_acc <= r_aspec_val;
                    end else if (r_sum == 64'd0) begin
                        r_acc <= 32'd0;
                    end else begin
                        r_acc <= fp_round(r_as, r_ax, r_sum);
                    end
                    r_k     <= r_k + KW'(1);
                    r_state <= (r_k == KW'(MATRIX_SIZE - 1)) ? S_DONE : S_READ;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_value <= r_acc;
                        r_out_row   <= r_row;
                        r_out_col   <= r_col;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
